// ===== rtl/lkvc_pkg.sv =====
// Package for the LRU key-value cache: request codes, defaults, shared types.
// Used by every module of the cache; depends on nothing.
package lkvc_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FUNC_W  = 2;
    localparam int FIELD_W = 32;
    localparam int CAP_W   = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [FUNC_W-1:0] FUNC_GET      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUT      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 2'd2;
    // Unused code; the cache treats it like a contains.
    localparam logic [FUNC_W-1:0] FUNC_SPARE    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic lookup;   // Register the compare result for the latched item.
        logic update;   // Apply the item to the table.
        logic evict;    // Drop the least recent entry.
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic is_put;
        logic full;
    } t_status;

endpackage

// ===== rtl/lkvc_ctrl.sv =====
// Controller state machine of the LRU key-value cache.
// Depends on lkvc_pkg.
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_take
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_EVICT = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_take      = o_in_ready && i_in_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state = S_EVICT;
            end
            S_EVICT: begin
                if (i_status.is_put && !i_status.hit && i_status.full) o_cmd.evict = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/lkvc_datapath.sv =====
// Datapath of the LRU key-value cache: entry registers, key compare, ranks.
// Depends on lkvc_pkg.
module lkvc_datapath
    import lkvc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [FIELD_W-1:0] i_key,
    input  logic [FIELD_W-1:0] i_value,
    input  logic [CAP_W-1:0]   i_capacity,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic               o_hit,
    output logic [FIELD_W-1:0] o_read_value,
    output logic [CAP_W-1:0]   o_occupancy
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [FUNC_W-1:0]     r_func;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [ENTRIES-1:0]    r_valid;
    logic [KEY_BITS-1:0]   r_ekey [ENTRIES];
    logic [VALUE_BITS-1:0] r_edata [ENTRIES];
    logic [IDX_W-1:0]      r_rank [ENTRIES];
    logic [CNT_W-1:0]      r_used;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_slot;
    logic [FIELD_W-1:0]    r_rd;

    logic [ENTRIES-1:0] match;
    logic [IDX_W-1:0]   match_idx, free_idx;
    logic               any_match;
    logic [CNT_W-1:0]   cap_eff;

    // Parallel key compare and first free slot.
    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            match[i] = r_valid[i] && (r_ekey[i] == r_key);
            if (match[i]) match_idx = IDX_W'(i);
            if (!r_valid[i]) free_idx = IDX_W'(i);
        end
        any_match = |match;
    end

    // Clamp the capacity register into 1..ENTRIES.
    always_comb begin
        if (i_capacity == '0) begin
            cap_eff = CNT_W'(1);
        end else if (32'(i_capacity) > ENTRIES) begin
            cap_eff = CNT_W'(ENTRIES);
        end else begin
            cap_eff = CNT_W'(i_capacity);
        end
    end

    assign o_status.hit    = r_hit;
    assign o_status.is_put = (r_func == FUNC_PUT);
    assign o_status.full   = (r_used >= cap_eff);
    assign o_hit        = r_hit;
    assign o_read_value = r_rd;
    assign o_occupancy  = CAP_W'(r_used);

    // Item latch, lookup result and read data.
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_func  <= i_func;
            r_key   <= KEY_BITS'(i_key);
            r_value <= VALUE_BITS'(i_value);
        end
        if (i_cmd.lookup) begin
            r_hit  <= any_match;
            r_slot <= match_idx;
            r_rd   <= (any_match && r_func == FUNC_GET) ?
                      FIELD_W'(r_edata[match_idx]) : '0;
        end
        if (i_cmd.update && r_func == FUNC_PUT) begin
            if (r_hit) begin
                r_edata[r_slot] <= r_value;
            end else if (!r_valid[free_idx]) begin
                r_ekey[free_idx]  <= r_key;
                r_edata[free_idx] <= r_value;
            end
        end
    end

    // Valid bits, ranks and the used count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= '0;
        end else if (i_cmd.evict) begin
            // The least recent entry holds rank used-1.
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && r_rank[i] == IDX_W'(r_used - CNT_W'(1))) begin
                    r_valid[i] <= 1'b0;
                    r_rank[i]  <= '0;
                end
            end
            r_used <= r_used - CNT_W'(1);
        end else if (i_cmd.update) begin
            if (r_hit && (r_func == FUNC_GET || r_func == FUNC_PUT)) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && r_rank[i] < r_rank[r_slot]) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
                r_rank[r_slot] <= '0;
            end else if (!r_hit && r_func == FUNC_PUT && !r_valid[free_idx]) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i]) r_rank[i] <= r_rank[i] + IDX_W'(1);
                end
                r_valid[free_idx] <= 1'b1;
                r_rank[free_idx]  <= '0;
                r_used <= r_used + CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// LRU key-value cache with ENTRIES fully associative slots. An accepted item
// passes through the compare, evict and update states before its result is
// offered. The next item is accepted in the cycle after the result is taken,
// so the cache holds only one item at a time and a stalled result holds off
// the next item. Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.
module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CAP_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [FIELD_W-1:0] i_lookup_key,
    input  logic [FIELD_W-1:0] i_write_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit,
    output logic [FIELD_W-1:0] o_read_value,
    output logic [CAP_W-1:0]   o_occupancy
);

    logic [CAP_W-1:0] r_capacity;
    t_cmd    cmd;
    t_status status;
    logic    take;

    // Capacity register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    lkvc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_status(status), .o_cmd(cmd), .o_take(take)
    );

    lkvc_datapath #(
        .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_func(i_func), .i_key(i_lookup_key), .i_value(i_write_value),
        .i_capacity(r_capacity), .i_cmd(cmd), .o_status(status),
        .o_hit(o_hit), .o_read_value(o_read_value), .o_occupancy(o_occupancy)
    );

endmodule

// ===== rtl/lkvc_checker.sv =====
// Port-level checker for the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_top.
module lkvc_checker
    import lkvc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               i_in_valid,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_hit,
    input logic [FIELD_W-1:0] o_read_value,
    input logic [CAP_W-1:0]   o_occupancy
);

    // A result never appears in the same cycle a new item can be taken.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready)) else $error("ready while result pending");

    // An accepted item closes the input until its result has gone.
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready) else $error("ready after take");

    // A miss never returns data.
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_read_value == '0)) else $error("miss with data");

    // Occupancy never exceeds the table size.
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_occupancy <= CAP_W'(ENTRIES_DEF))) else $error("occupancy");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_read_value)))
        else $error("result changed");

endmodule

bind lru_key_value_cache_top lkvc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .i_in_valid(i_in_valid), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_hit(o_hit), .o_read_value(o_read_value), .o_occupancy(o_occupancy)
);

// ===== sim/lru_cache_checker.sv =====
// Checker for the LRU key-value cache: watches the config, request and result
// channels, keeps its own table and compares every result. Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lru_cache_checker
    import lkvc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CAP_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [FIELD_W-1:0] i_lookup_key,
    input  logic [FIELD_W-1:0] i_write_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_hit,
    input  logic [FIELD_W-1:0] i_read_value,
    input  logic [CAP_W-1:0]   i_occupancy,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int SLOTS = ENTRIES_DEF;

    typedef struct packed {
        logic               hit;
        logic [FIELD_W-1:0] value;
        logic [CAP_W-1:0]   occ;
    } t_answer;

    // Shadow copy of the table.
    logic               slot_valid [SLOTS];
    logic [FIELD_W-1:0] slot_key   [SLOTS];
    logic [FIELD_W-1:0] slot_data  [SLOTS];
    int                 slot_rank  [SLOTS];
    int                 used;
    logic [CAP_W-1:0]   capacity;
    t_answer            answers_due [$];

    assign o_pending = answers_due.size();

    task automatic report(input string what, input logic [FIELD_W-1:0] got,
                          input logic [FIELD_W-1:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_errors = o_errors + 1;
    endtask

    // Move one slot to rank zero, aging those that were more recent.
    function automatic void promote(input int s);
        int r;
        r = slot_rank[s];
        for (int j = 0; j < SLOTS; j++)
            if (slot_valid[j] && slot_rank[j] < r) slot_rank[j]++;
        slot_rank[s] = 0;
    endfunction

    // Apply one request to the shadow table and return its answer.
    function automatic t_answer lookup_and_update(input logic [FUNC_W-1:0] f,
                                                  input logic [FIELD_W-1:0] k,
                                                  input logic [FIELD_W-1:0] d);
        t_answer a;
        int s, cap, worst, victim, free_slot;
        s = -1;
        a = '0;
        for (int j = 0; j < SLOTS; j++)
            if (s < 0 && slot_valid[j] && slot_key[j] == k) s = j;
        cap = int'(capacity);
        if (cap < 1) cap = 1;
        if (cap > SLOTS) cap = SLOTS;
        a.hit = (s >= 0);
        if (f == FUNC_GET && s >= 0) begin
            a.value = slot_data[s];
            promote(s);
        end else if (f == FUNC_PUT && s >= 0) begin
            slot_data[s] = d;
            promote(s);
        end else if (f == FUNC_PUT) begin
            if (used >= cap) begin
                victim = -1;
                worst = 0;
                for (int j = 0; j < SLOTS; j++)
                    if (slot_valid[j] && (victim < 0 || slot_rank[j] >= worst)) begin
                        worst = slot_rank[j];
                        victim = j;
                    end
                if (victim >= 0) begin
                    slot_valid[victim] = 1'b0;
                    slot_rank[victim] = 0;
                    used--;
                end
            end
            free_slot = -1;
            for (int j = 0; j < SLOTS; j++)
                if (!slot_valid[j] && free_slot < 0) free_slot = j;
            if (free_slot >= 0) begin
                for (int j = 0; j < SLOTS; j++)
                    if (slot_valid[j]) slot_rank[j]++;
                slot_valid[free_slot] = 1'b1;
                slot_key[free_slot] = k;
                slot_data[free_slot] = d;
                slot_rank[free_slot] = 0;
                used++;
            end
        end
        a.occ = used[CAP_W-1:0];
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int j = 0; j < SLOTS; j++) begin
                slot_valid[j] = 1'b0;
                slot_key[j] = '0;
                slot_data[j] = '0;
                slot_rank[j] = 0;
            end
            used = 0;
            capacity = CAP_RESET;
            o_errors = 0;
            answers_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) capacity = i_cfg_data;
            // Results leave first; the request path cannot answer in the same edge.
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    report("unexpected result item", '0, '0);
                end else begin
                    want = answers_due.pop_front();
                    if (i_hit !== want.hit)
                        report("hit", FIELD_W'(i_hit), FIELD_W'(want.hit));
                    if (i_read_value !== want.value)
                        report("read_value", i_read_value, want.value);
                    if (i_occupancy !== want.occ)
                        report("occupancy", FIELD_W'(i_occupancy), FIELD_W'(want.occ));
                end
            end
            if (i_in_valid && i_in_ready)
                answers_due.insert(answers_due.size(),
                                   lookup_and_update(i_func, i_lookup_key, i_write_value));
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the LRU key-value cache: clock, reset, request and config
// stimulus, random result stalls and the verdict. Depends on lkvc_pkg,
// lru_key_value_cache_top and lru_cache_checker.
`timescale 1ns / 1ps

module tb
    import lkvc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [FUNC_W-1:0]  func;
    logic [FIELD_W-1:0] lookup_key;
    logic [FIELD_W-1:0] write_value;
    logic               out_valid;
    logic               out_ready;
    logic               hit;
    logic [FIELD_W-1:0] read_value;
    logic [CAP_W-1:0]   occupancy;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    logic [FIELD_W-1:0] key_pool [8];

    lru_key_value_cache_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_func(func),
        .i_lookup_key(lookup_key), .i_write_value(write_value),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_hit(hit),
        .o_read_value(read_value), .o_occupancy(occupancy)
    );

    lru_cache_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_func(func),
        .i_lookup_key(lookup_key), .i_write_value(write_value),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_hit(hit),
        .i_read_value(read_value), .i_occupancy(occupancy),
        .o_errors(errors), .o_pending(pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Gap lengths: mostly none or short, now and then long.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side stalls at random.
    always @(posedge clk) begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(0, 99) < 70);
    end

    // Watchdog on cycles with no accepted item on any channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Valid stays high between items sent with no gap; it drops only for a gap.
    task automatic send_request(input logic [FUNC_W-1:0] f,
                                input logic [FIELD_W-1:0] k,
                                input logic [FIELD_W-1:0] d);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        lookup_key <= k;
        write_value <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly keys from a small pool so hits and evictions happen often.
    task automatic random_phase(input int count, input int pool_size);
        logic [FIELD_W-1:0] k;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, pool_size - 1)];
            else k = $urandom();
            send_request(FUNC_W'($urandom_range(0, 3)), k, $urandom());
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_GET;
        lookup_key = '0;
        write_value = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int j = 0; j < 8; j++) key_pool[j] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;

        // Directed: empty lookups, field extremes, every request kind.
        send_request(FUNC_GET, '0, '0);
        send_request(FUNC_CONTAINS, '1, '1);
        send_request(FUNC_PUT, '0, '1);
        send_request(FUNC_PUT, '1, '0);
        send_request(FUNC_GET, '0, '0);
        send_request(FUNC_GET, '1, '1);
        send_request(FUNC_PUT, '0, 32'h5a5a_a5a5);
        send_request(FUNC_CONTAINS, '0, '1);
        send_request(FUNC_SPARE, '1, '1);
        send_request(FUNC_GET, '0, '0);
        // Fill past default capacity to force an eviction.
        for (int j = 0; j < 17; j++) send_request(FUNC_PUT, 32'h100 + j, ~j);

        // Lower capacity below occupancy, then zero, then above range.
        set_capacity(5'd3);
        send_request(FUNC_PUT, 32'hdead_beef, 32'h1);
        send_request(FUNC_GET, 32'h110, 0);
        random_phase(100, 4);
        set_capacity(5'd0);
        random_phase(80, 3);
        set_capacity(5'd31);
        random_phase(150, 8);
        set_capacity(5'd1);
        random_phase(80, 3);
        set_capacity(5'd16);
        random_phase(150, 8);
        set_capacity(5'd5);
        random_phase(160, 8);

        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
